FILE: hdl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

    // Tag value that marks an unused slot; it is never installed.
    localparam logic [31:0] INVALID_TAG = 32'hffff_ffff;

    // Sequencer states of the tag store.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Commands from the sequencer to the recency unit.
    typedef struct packed {
        logic rotate;   // step every age one place toward the head
        logic promote;  // make one slot most recent and age the younger ones
        logic clear;    // return the order to its reset state
    } t_age_ctl;

endpackage

FILE: hdl/lsc_age.sv
`timescale 1ns / 1ps

module lsc_age import lsc_pkg::*; #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_age_ctl                     i_ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_slot,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_age,
    output logic [$clog2(NUM_SLOTS)-1:0] o_head
);

    localparam int IW = $clog2(NUM_SLOTS);

    // Age of each slot: its position in the recency order, 0 is most recent.
    // While a scan runs the ages turn as a ring, so the head always holds the
    // age of the slot being compared; a full scan brings them back in place.
    logic [IW-1:0] r_age [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!i_rst_n || i_ctl.clear) begin
                r_age[i] <= IW'(i);
            end else if (i_ctl.rotate) begin
                r_age[i] <= (i == NUM_SLOTS - 1) ? r_age[0] : r_age[(i + 1) % NUM_SLOTS];
            end else if (i_ctl.promote) begin
                if (i_slot == IW'(i)) begin
                    r_age[i] <= '0;
                end else if (r_age[i] < i_age) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
        end
    end

    assign o_head = r_age[0];

endmodule

FILE: hdl/lru_sector_cache_tags.sv
`timescale 1ns / 1ps
// Access request: after start the sequencer reads and compares every slot, one tag compare
// per cycle from the tag memory, then reports; busy stays high until the result strobe.
// Flush request: NUM_SLOTS results on consecutive cycles, each read from the tag memory and then registered.
// An access request with the reserved all-ones block number answers in the next cycle.
// Synchronous active-low reset empties every slot; no clearing pass is needed.
// Results are shown for one cycle only; the receiver cannot stall them.

module lru_sector_cache_tags import lsc_pkg::*; #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_block_number,
    input  logic        i_write_access,
    output logic        o_strobe,
    output logic        o_hit,
    output logic [2:0]  o_slot,
    output logic        o_victim_valid,
    output logic [31:0] o_victim_block,
    output logic        o_victim_dirty,
    output logic        o_last
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);

    // Sequencer and request registers.
    logic [1:0]           r_state;
    logic                 r_mode;
    logic [31:0]          r_blk;
    logic                 r_wr;
    logic [IW-1:0]        r_idx;
    logic                 r_iss_done;

    // Tag memory with registered read, plus per-slot valid and dirty bits.
    logic [31:0]          r_tag_mem [NUM_SLOTS];
    logic [31:0]          r_rd_data;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_dirty;

    // Scan results.
    logic                 r_hit;
    logic [IW-1:0]        r_hit_slot;
    logic [IW-1:0]        r_hit_age;
    logic [IW-1:0]        r_vic_slot;
    logic                 r_vic_valid;
    logic [31:0]          r_vic_tag;
    logic                 r_vic_dirty;

    // Output registers.
    logic                 r_strobe;
    logic                 r_out_hit;
    logic [2:0]           r_out_slot;
    logic                 r_out_vvalid;
    logic [31:0]          r_out_vblock;
    logic                 r_out_vdirty;
    logic                 r_out_last;

    logic                 accept;
    logic                 reserved;
    logic                 rd_en;
    logic                 cmp_ok;
    logic                 cmp_match;
    logic                 cmp_last;
    logic                 mem_wr;
    logic [IW-1:0]        age_head;
    logic [IW-1:0]        pro_slot;
    logic [IW-1:0]        pro_age;
    t_age_ctl             age_ctl;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign reserved = !i_mode && (i_block_number == INVALID_TAG);
    assign rd_en    = (r_state == S_SCAN) && !r_iss_done;
    assign cmp_ok    = r_valid[r_rd_idx];
    assign cmp_match = cmp_ok && (r_rd_data == r_blk);
    assign cmp_last  = r_rd_vld && (r_rd_idx == LAST_SLOT);
    assign mem_wr    = (r_state == S_FIN) && !r_hit;

    // The promoted slot is the hit slot, or on a miss the victim, which is oldest.
    assign pro_slot = r_hit ? r_hit_slot : r_vic_slot;
    assign pro_age  = r_hit ? r_hit_age : LAST_SLOT;

    assign age_ctl.rotate  = r_rd_vld;
    assign age_ctl.promote = (r_state == S_FIN);
    assign age_ctl.clear   = cmp_last && r_mode;

    lsc_age #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (age_ctl),
        .i_slot  (pro_slot),
        .i_age   (pro_age),
        .o_head  (age_head)
    );

    // Tag memory: one read per slot during a scan, one write when a miss installs a block.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_tag_mem[r_idx];
        end
        if (mem_wr) begin
            r_tag_mem[r_vic_slot] <= r_blk;
        end
    end

    // Sequencer, compare stage, slot status and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iss_done <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_valid    <= '0;
            r_dirty    <= '0;
            r_hit      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= rd_en;
            r_rd_idx <= r_idx;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode     <= i_mode;
                        r_blk      <= i_block_number;
                        r_wr       <= i_write_access;
                        r_idx      <= '0;
                        r_iss_done <= 1'b0;
                        r_hit      <= 1'b0;
                        if (reserved) begin
                            // Reserved block number: answer at once, state untouched.
                            r_strobe     <= 1'b1;
                            r_out_hit    <= 1'b0;
                            r_out_slot   <= 3'd0;
                            r_out_vvalid <= 1'b0;
                            r_out_vblock <= '0;
                            r_out_vdirty <= 1'b0;
                            r_out_last   <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one tag read per cycle until every slot is read.
                    if (rd_en) begin
                        if (r_idx == LAST_SLOT) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end

                    if (r_rd_vld) begin
                        if (r_mode) begin
                            // Flush: report the slot just read.
                            r_strobe     <= 1'b1;
                            r_out_hit    <= 1'b0;
                            r_out_slot   <= 3'(r_rd_idx);
                            r_out_vvalid <= cmp_ok;
                            r_out_vblock <= cmp_ok ? r_rd_data : '0;
                            r_out_vdirty <= cmp_ok && r_dirty[r_rd_idx];
                            r_out_last   <= (r_rd_idx == LAST_SLOT);
                        end else begin
                            if (cmp_match && !r_hit) begin
                                r_hit      <= 1'b1;
                                r_hit_slot <= r_rd_idx;
                                r_hit_age  <= age_head;
                            end
                            if (age_head == LAST_SLOT) begin
                                r_vic_slot  <= r_rd_idx;
                                r_vic_valid <= cmp_ok;
                                r_vic_tag   <= r_rd_data;
                                r_vic_dirty <= r_dirty[r_rd_idx];
                            end
                        end
                    end

                    if (cmp_last) begin
                        if (r_mode) begin
                            r_valid <= '0;
                            r_dirty <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    // Report the access and update the hit or victim slot.
                    r_strobe   <= 1'b1;
                    r_out_hit  <= r_hit;
                    r_out_last <= 1'b1;
                    if (r_hit) begin
                        r_out_slot   <= 3'(r_hit_slot);
                        r_out_vvalid <= 1'b0;
                        r_out_vblock <= '0;
                        r_out_vdirty <= 1'b0;
                        if (r_wr) begin
                            r_dirty[r_hit_slot] <= 1'b1;
                        end
                    end else begin
                        r_out_slot           <= 3'(r_vic_slot);
                        r_out_vvalid         <= r_vic_valid;
                        r_out_vblock         <= r_vic_valid ? r_vic_tag : '0;
                        r_out_vdirty         <= r_vic_valid && r_vic_dirty;
                        r_valid[r_vic_slot]  <= 1'b1;
                        r_dirty[r_vic_slot]  <= r_wr;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_hit          = r_out_hit;
    assign o_slot         = r_out_slot;
    assign o_victim_valid = r_out_vvalid;
    assign o_victim_block = r_out_vblock;
    assign o_victim_dirty = r_out_vdirty;
    assign o_last         = r_out_last;

    // A hit never reports a victim.
    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_hit |-> !o_victim_valid && (o_victim_block == '0) && !o_victim_dirty)
        else $error("hit result carries victim data");

    // The sequencer goes idle only together with the final result of a request.
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe && o_last)
        else $error("request finished without its last result");

    // Flush results come on consecutive cycles until the last one.
    a_flush_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside a flush result run");

    // A request that needs a scan makes the block busy.
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !reserved |=> busy && (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

endmodule

FILE: test/lru_sector_cache_tags_tb.sv
`timescale 1ns / 1ps

module lru_sector_cache_tags_tb;
    import lsc_pkg::*;

    localparam int NUM_SLOTS   = 8;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTLE      = NUM_SLOTS + 4;
    localparam int PHASE_ITEMS = 135;
    localparam int POOL_SIZE   = 12;

    // Request modes.
    localparam bit MODE_ACCESS = 1'b0;
    localparam bit MODE_FLUSH  = 1'b1;

    typedef struct packed {
        bit        hit;
        bit [2:0]  slot;
        bit        victim_valid;
        bit [31:0] victim_block;
        bit        victim_dirty;
        bit        last;
    } t_tag_result;

    typedef struct packed {
        bit          mode;
        bit [31:0]   blk;
        bit          wr;
        bit          pinned;
        t_tag_result res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_mode = MODE_ACCESS;
    logic [31:0] i_block_number = 32'h0;
    logic        i_write_access = 1'b0;
    logic        busy;
    logic        o_strobe;
    logic        o_hit;
    logic [2:0]  o_slot;
    logic        o_victim_valid;
    logic [31:0] o_victim_block;
    logic        o_victim_dirty;
    logic        o_last;

    // A typed-in expectation travels with the request that it belongs to.
    bit          pinned_check = 1'b0;
    t_tag_result pinned_result = '0;

    // Shadow copy of the tag store.
    bit [31:0] tag_mem[NUM_SLOTS];
    bit        dirty_mem[NUM_SLOTS];
    bit [2:0]  age_order[NUM_SLOTS];

    t_tag_result expected_results[$];
    int          mismatch_count = 0;
    bit [31:0]   hot_blocks[POOL_SIZE];
    int          phase_idle[3] = '{0, 53, 25};

    // Directed requests; single-result rows that are obvious carry their answer.
    t_stim_row directed_rows[17] = '{
        '{MODE_ACCESS, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 3'd7, 1'b0, 32'h0, 1'b0, 1'b1}},
        '{MODE_ACCESS, 32'hffff_fffe, 1'b1, 1'b1, '{1'b0, 3'd6, 1'b0, 32'h0, 1'b0, 1'b1}},
        '{MODE_ACCESS, 32'hffff_ffff, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b1}},
        '{MODE_ACCESS, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 3'd7, 1'b0, 32'h0, 1'b0, 1'b1}},
        '{MODE_ACCESS, 32'haaaa_aaaa, 1'b0, 1'b0, '0},
        '{MODE_ACCESS, 32'h5555_5555, 1'b1, 1'b0, '0},
        '{MODE_ACCESS, 32'h0000_0001, 1'b0, 1'b0, '0},
        '{MODE_ACCESS, 32'h0000_0002, 1'b1, 1'b0, '0},
        '{MODE_ACCESS, 32'h0000_0003, 1'b0, 1'b0, '0},
        '{MODE_ACCESS, 32'h0000_0004, 1'b1, 1'b0, '0},
        '{MODE_ACCESS, 32'h1234_5678, 1'b0, 1'b0, '0},
        '{MODE_ACCESS, 32'h5555_5555, 1'b0, 1'b0, '0},
        '{MODE_FLUSH,  32'hdead_beef, 1'b1, 1'b0, '0},
        '{MODE_FLUSH,  32'hffff_ffff, 1'b0, 1'b0, '0},
        '{MODE_ACCESS, 32'hffff_ffff, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b1}},
        '{MODE_ACCESS, 32'h8000_0000, 1'b1, 1'b1, '{1'b0, 3'd7, 1'b0, 32'h0, 1'b0, 1'b1}},
        '{MODE_FLUSH,  32'h0000_0000, 1'b0, 1'b0, '0}
    };

    always #1 i_clk = ~i_clk;

    lru_sector_cache_tags #(
        .NUM_SLOTS(NUM_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_block_number(i_block_number),
        .i_write_access(i_write_access),
        .o_strobe(o_strobe),
        .o_hit(o_hit),
        .o_slot(o_slot),
        .o_victim_valid(o_victim_valid),
        .o_victim_block(o_victim_block),
        .o_victim_dirty(o_victim_dirty),
        .o_last(o_last)
    );

    // Return the shadow store to its empty state.
    task automatic clear_tags();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            tag_mem[s] = INVALID_TAG;
            dirty_mem[s] = 1'b0;
            age_order[s] = s[2:0];
        end
    endtask

    // Move a slot to the most recent position, aging the younger ones by one.
    task automatic touch_slot(input bit [2:0] s);
        int pos;
        pos = NUM_SLOTS - 1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (age_order[i] == s) pos = i;
        end
        for (int i = pos; i > 0; i--) age_order[i] = age_order[i - 1];
        age_order[0] = s;
    endtask

    // Work out the results of one request and update the shadow store.
    task automatic predict_lookup(input bit mode, input bit [31:0] blk, input bit wr);
        t_tag_result r;
        bit [2:0]    target;
        bit          found;
        if (mode == MODE_FLUSH) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r = '0;
                r.slot = s[2:0];
                if (tag_mem[s] != INVALID_TAG) begin
                    r.victim_valid = 1'b1;
                    r.victim_block = tag_mem[s];
                    r.victim_dirty = dirty_mem[s];
                end
                r.last = (s == NUM_SLOTS - 1);
                expected_results.push_back(r);
            end
            clear_tags();
        end else if (blk == INVALID_TAG) begin
            r = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
        end else begin
            found = 1'b0;
            target = 3'd0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (!found && tag_mem[s] == blk) begin
                    found = 1'b1;
                    target = s[2:0];
                end
            end
            r = '0;
            r.last = 1'b1;
            if (found) begin
                r.hit = 1'b1;
                if (wr) dirty_mem[target] = 1'b1;
            end else begin
                target = age_order[NUM_SLOTS - 1];
                if (tag_mem[target] != INVALID_TAG) begin
                    r.victim_valid = 1'b1;
                    r.victim_block = tag_mem[target];
                    r.victim_dirty = dirty_mem[target];
                end
                tag_mem[target] = blk;
                dirty_mem[target] = wr;
            end
            r.slot = target;
            touch_slot(target);
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Record accepted requests and compare every strobed result.
    always @(posedge i_clk) begin
        t_tag_result want;
        if (i_rst_n && start && busy === 1'b0) begin
            predict_lookup(i_mode, i_block_number, i_write_access);
            if (pinned_check) begin
                void'(expected_results.pop_back());
                expected_results.push_back(pinned_result);
            end
        end
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: slot %0d", o_slot);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("slot", 32'(want.slot), 32'(o_slot));
                check_field("victim_valid", 32'(want.victim_valid), 32'(o_victim_valid));
                check_field("victim_block", want.victim_block, o_victim_block);
                check_field("victim_dirty", 32'(want.victim_dirty), 32'(o_victim_dirty));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input bit mode, input bit [31:0] blk, input bit wr,
                                input bit pinned, input t_tag_result res);
        start <= 1'b1;
        i_mode <= mode;
        i_block_number <= blk;
        i_write_access <= wr;
        pinned_check <= pinned;
        pinned_result <= res;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Mostly reuse a small set of blocks so hits, evictions and write-backs recur.
    task automatic send_random(input int idle_pct);
        bit [31:0] blk;
        bit        mode;
        bit        wr;
        int        pick;
        mode = MODE_ACCESS;
        wr = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 70) blk = hot_blocks[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 86) blk = $urandom;
        else if (pick < 91) blk = INVALID_TAG;
        else if (pick < 94) blk = ($urandom_range(1) != 0) ? 32'hffff_fffe : 32'h0;
        else begin
            blk = $urandom;
            mode = MODE_FLUSH;
        end
        send_request(mode, blk, wr, 1'b0, '0);
        idle_gap(idle_pct);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus sequence: reset, directed table, random phases, drain.
    initial begin
        int waited;
        clear_tags();
        for (int k = 0; k < POOL_SIZE; k++) begin
            hot_blocks[k] = $urandom;
            if (hot_blocks[k] == INVALID_TAG) hot_blocks[k] = 32'h0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].mode, directed_rows[k].blk, directed_rows[k].wr,
                         directed_rows[k].pinned, directed_rows[k].res);
            idle_gap(30);
        end
        wait_drained();

        foreach (phase_idle[p]) begin
            for (int n = 0; n < PHASE_ITEMS; n++) send_random(phase_idle[p]);
            wait_drained();
        end

        start <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0)
            $error("%0d expected results never arrived", expected_results.size());

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
